@@ src/sfca_pkg.sv @@
package sfca_pkg;

  localparam int DiskChunksDef  = 4096;
  localparam int MaxNodesDef    = 4096;
  localparam int MaxRequestDef  = 320;
  localparam int SizeClassesDef = 322;

  localparam int CfgW = 13;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_BAD_LOC  = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [8:0]  request_size;
    logic [11:0] free_location;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_location;
  } out_t;

  typedef struct packed {
    logic clr_all;
    logic wr;
    logic val;
  } occ_cmd_t;

endpackage

@@ src/sfca_ram.sv @@
module sfca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sfca_occ.sv @@
module sfca_occ #(
  parameter int SIZE_CLASSES = 322
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfca_pkg::occ_cmd_t              cmd_i,
  input  logic [$clog2(SIZE_CLASSES)-1:0] widx_i,
  input  logic [$clog2(SIZE_CLASSES)-1:0] qidx_i,
  output logic                            qbit_o,
  input  logic [$clog2(SIZE_CLASSES)-1:0] base_i,
  output logic                            found_o,
  output logic [$clog2(SIZE_CLASSES)-1:0] fidx_o
);
  import sfca_pkg::*;

  localparam int CW = $clog2(SIZE_CLASSES);

  logic [SIZE_CLASSES-1:0] occ_q, occ_d;

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.clr_all) begin
      occ_d = '0;
    end
    if (cmd_i.wr) begin
      occ_d[widx_i] = cmd_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign qbit_o = occ_q[qidx_i];

  // lowest occupied class at or above the base
  always_comb begin
    found_o = 1'b0;
    fidx_o  = '0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (occ_q[i] && (CW'(i) >= base_i)) begin
        found_o = 1'b1;
        fidx_o  = CW'(i);
      end
    end
  end

endmodule

@@ src/segregated_fit_chunk_allocator_unit.sv @@
// Every request, whether a bad size, no space, a bad free location, an exact fit, a split or a free,
// ends in one result beat.
// One item at a time: the next beat is taken in the cycle the result goes valid, so the
// serial read-modify-write steps on the node memory set the throughput; a stalled result holds it.
// Reset runs a clearing pass over the location table and then rebuilds one free segment of
// disk_size chunks; a disk_size write rebuilds the segment but runs no clearing pass.
module segregated_fit_chunk_allocator_unit #(
  parameter int DISK_CHUNKS  = sfca_pkg::DiskChunksDef,
  parameter int MAX_NODES    = sfca_pkg::MaxNodesDef,
  parameter int MAX_REQUEST  = sfca_pkg::MaxRequestDef,
  parameter int SIZE_CLASSES = sfca_pkg::SizeClassesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sfca_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sfca_pkg::out_t            out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sfca_pkg::CfgW-1:0] cfg_data_i
);
  import sfca_pkg::*;

  localparam int LW = $clog2(DISK_CHUNKS);
  localparam int SW = $clog2(DISK_CHUNKS + 1);
  localparam int NW = $clog2(MAX_NODES);
  localparam int FW = $clog2(MAX_NODES + 1);
  localparam int CW = $clog2(SIZE_CLASSES);
  localparam int AuxDepth = DISK_CHUNKS + SIZE_CLASSES;
  localparam int AW = $clog2(AuxDepth);

  typedef struct packed {
    logic [LW-1:0] start;
    logic [SW-1:0] size;
    logic          used;
    logic          has_left;
    logic [NW-1:0] left;
    logic          has_right;
    logic [NW-1:0] right;
    logic          has_cprev;
    logic [NW-1:0] cprev;
    logic          has_cnext;
    logic [NW-1:0] cnext;
  } node_t;

  localparam int NodeW = $bits(node_t);

  localparam logic [1:0] K_NEXT  = 2'd0;
  localparam logic [1:0] K_PREV  = 2'd1;
  localparam logic [1:0] K_RIGHT = 2'd2;
  localparam logic [1:0] K_LEFT  = 2'd3;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DONE   = 5'd2;
  localparam logic [4:0] S_A_SRCH = 5'd3;
  localparam logic [4:0] S_A_HD   = 5'd4;
  localparam logic [4:0] S_A_HRD  = 5'd5;
  localparam logic [4:0] S_A_POP  = 5'd6;
  localparam logic [4:0] S_A_EX   = 5'd7;
  localparam logic [4:0] S_A_SP1  = 5'd8;
  localparam logic [4:0] S_A_SP2  = 5'd9;
  localparam logic [4:0] S_A_SP3  = 5'd10;
  localparam logic [4:0] S_F_MAP  = 5'd11;
  localparam logic [4:0] S_F_SRD  = 5'd12;
  localparam logic [4:0] S_F_LRD  = 5'd13;
  localparam logic [4:0] S_F_L2   = 5'd14;
  localparam logic [4:0] S_F_L3   = 5'd15;
  localparam logic [4:0] S_F_R0   = 5'd16;
  localparam logic [4:0] S_F_RRD  = 5'd17;
  localparam logic [4:0] S_F_R2   = 5'd18;
  localparam logic [4:0] S_F_R3   = 5'd19;
  localparam logic [4:0] S_F_PU   = 5'd20;
  localparam logic [4:0] S_F_DONE = 5'd21;
  localparam logic [4:0] S_RM0    = 5'd22;
  localparam logic [4:0] S_RM1    = 5'd23;
  localparam logic [4:0] S_PU0    = 5'd24;
  localparam logic [4:0] S_PU1    = 5'd25;
  localparam logic [4:0] S_RMW_RD = 5'd26;
  localparam logic [4:0] S_RMW_WR = 5'd27;

  function automatic logic [CW-1:0] cls_of(input logic [SW-1:0] sz);
    if (32'(sz) >= SIZE_CLASSES - 1) begin
      return CW'(SIZE_CLASSES - 1);
    end
    return CW'(sz);
  endfunction

  logic [4:0] st_q, st_d, rm_ret_q, rm_ret_d, pu_ret_q, pu_ret_d, rmw_ret_q, rmw_ret_d;
  logic [SW-1:0] disk_q, disk_d;
  logic rb_pend_q, rb_pend_d;
  logic [LW-1:0] clr_q, clr_d;
  logic [FW-1:0] fresh_q, fresh_d;
  logic [NW-1:0] top_q, top_d;
  logic top_v_q, top_v_d;
  logic out_v_q, out_v_d;
  out_t out_q, out_d;
  logic [1:0] res_st_q, res_st_d;
  logic [11:0] res_loc_q, res_loc_d;

  logic [8:0] req_q, req_d;
  logic [11:0] loc_q, loc_d;
  logic [NW-1:0] sid_q, sid_d, pid_q, pid_d, nid_q, nid_d;
  node_t s_q, s_d, p_q, p_d, n_q, n_d, rm_q, rm_d;
  logic [NW-1:0] rmw_id_q, rmw_id_d, rmw_val_q, rmw_val_d;
  logic [1:0] rmw_kind_q, rmw_kind_d;
  logic rmw_has_q, rmw_has_d;

  logic node_we;
  logic [NW-1:0] node_waddr, node_raddr;
  node_t node_wdata, node_rdata;
  logic [NodeW-1:0] node_rbits;
  logic aux_we;
  logic [AW-1:0] aux_waddr, aux_raddr;
  logic [NW-1:0] aux_wdata, aux_rdata;

  occ_cmd_t occ_cmd;
  logic [CW-1:0] occ_widx, occ_qidx, occ_fidx;
  logic occ_qbit, occ_found;
  logic [12:0] cfg_sat;

  sfca_ram #(.WIDTH(NodeW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rbits)
  );
  assign node_rdata = node_t'(node_rbits);

  // location table in the low part, class heads above it
  sfca_ram #(.WIDTH(NW), .DEPTH(AuxDepth)) u_aux_ram (
    .clk_i   (clk_i),
    .we_i    (aux_we),
    .waddr_i (aux_waddr),
    .wdata_i (aux_wdata),
    .raddr_i (aux_raddr),
    .rdata_o (aux_rdata)
  );

  sfca_occ #(.SIZE_CLASSES(SIZE_CLASSES)) u_occ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (occ_cmd),
    .widx_i  (occ_widx),
    .qidx_i  (occ_qidx),
    .qbit_o  (occ_qbit),
    .base_i  (CW'(req_q)),
    .found_o (occ_found),
    .fidx_o  (occ_fidx)
  );

  assign in_stall_o  = !(st_q == S_IDLE && !rb_pend_q);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign cfg_sat = (32'(cfg_data_i) > DISK_CHUNKS) ? 13'(DISK_CHUNKS) : cfg_data_i;

  always_comb begin
    node_t w;
    logic [CW-1:0] c;
    st_d = st_q;
    rm_ret_d = rm_ret_q;
    pu_ret_d = pu_ret_q;
    rmw_ret_d = rmw_ret_q;
    disk_d = disk_q;
    rb_pend_d = rb_pend_q;
    clr_d = clr_q;
    fresh_d = fresh_q;
    top_d = top_q;
    top_v_d = top_v_q;
    out_v_d = out_v_q;
    out_d = out_q;
    res_st_d = res_st_q;
    res_loc_d = res_loc_q;
    req_d = req_q;
    loc_d = loc_q;
    sid_d = sid_q;
    pid_d = pid_q;
    nid_d = nid_q;
    s_d = s_q;
    p_d = p_q;
    n_d = n_q;
    rm_d = rm_q;
    rmw_id_d = rmw_id_q;
    rmw_val_d = rmw_val_q;
    rmw_kind_d = rmw_kind_q;
    rmw_has_d = rmw_has_q;
    node_we = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    aux_we = 1'b0;
    aux_waddr = '0;
    aux_wdata = '0;
    aux_raddr = '0;
    occ_cmd = '0;
    occ_widx = '0;
    occ_qidx = '0;
    w = '0;
    c = '0;

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    unique case (st_q) inside
      S_CLEAR: begin
        aux_we = 1'b1;
        aux_waddr = AW'(clr_q);
        aux_wdata = '0;
        clr_d = LW'(clr_q + 1'b1);
        if (32'(clr_q) == DISK_CHUNKS - 1) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (rb_pend_q) begin
          rb_pend_d = 1'b0;
          w.size = disk_q;
          node_we = 1'b1;
          node_waddr = '0;
          node_wdata = w;
          occ_cmd.clr_all = 1'b1;
          top_v_d = 1'b0;
          fresh_d = FW'(1);
          if (disk_q != '0) begin
            occ_cmd.wr = 1'b1;
            occ_cmd.val = 1'b1;
            occ_widx = cls_of(disk_q);
            aux_we = 1'b1;
            aux_waddr = AW'(DISK_CHUNKS + 32'(cls_of(disk_q)));
            aux_wdata = '0;
          end
        end else if (in_valid_i) begin
          req_d = in_data_i.request_size;
          loc_d = in_data_i.free_location;
          if (in_data_i.opcode == OP_ALLOC) begin
            if (in_data_i.request_size == '0 ||
                32'(in_data_i.request_size) > MAX_REQUEST) begin
              res_st_d = ST_BAD_SIZE;
              res_loc_d = '0;
              st_d = S_DONE;
            end else begin
              st_d = S_A_SRCH;
            end
          end else begin
            if (32'(in_data_i.free_location) >= DISK_CHUNKS) begin
              res_st_d = ST_BAD_LOC;
              res_loc_d = '0;
              st_d = S_DONE;
            end else begin
              aux_raddr = AW'(in_data_i.free_location);
              st_d = S_F_MAP;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_v_q || !out_stall_i) begin
          out_d.status = res_st_q;
          out_d.granted_location = res_loc_q;
          out_v_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      S_A_SRCH: begin
        if (!occ_found) begin
          res_st_d = ST_NO_SPACE;
          res_loc_d = '0;
          st_d = S_DONE;
        end else begin
          aux_raddr = AW'(DISK_CHUNKS + 32'(occ_fidx));
          st_d = S_A_HD;
        end
      end
      S_A_HD: begin
        sid_d = aux_rdata;
        node_raddr = aux_rdata;
        st_d = S_A_HRD;
      end
      S_A_HRD: begin
        s_d = node_rdata;
        if (32'(node_rdata.size) == 32'(req_q)) begin
          rm_d = node_rdata;
          rm_ret_d = S_A_EX;
          st_d = S_RM0;
        end else if (top_v_q) begin
          nid_d = top_q;
          node_raddr = top_q;
          st_d = S_A_POP;
        end else if (32'(fresh_q) < MAX_NODES) begin
          nid_d = NW'(fresh_q);
          fresh_d = FW'(fresh_q + 1'b1);
          rm_d = node_rdata;
          rm_ret_d = S_A_SP1;
          st_d = S_RM0;
        end else begin
          res_st_d = ST_NO_SPACE;
          res_loc_d = '0;
          st_d = S_DONE;
        end
      end
      S_A_POP: begin
        top_d = node_rdata.cnext;
        top_v_d = node_rdata.has_cnext;
        rm_d = s_q;
        rm_ret_d = S_A_SP1;
        st_d = S_RM0;
      end
      S_A_EX: begin
        w = s_q;
        w.used = 1'b1;
        node_we = 1'b1;
        node_waddr = sid_q;
        node_wdata = w;
        aux_we = 1'b1;
        aux_waddr = AW'(s_q.start);
        aux_wdata = sid_q;
        res_st_d = ST_OK;
        res_loc_d = 12'(s_q.start);
        st_d = S_DONE;
      end
      S_A_SP1: begin
        n_d = '0;
        n_d.start = s_q.start;
        n_d.size = SW'(req_q);
        n_d.used = 1'b1;
        n_d.has_left = s_q.has_left;
        n_d.left = s_q.left;
        n_d.has_right = 1'b1;
        n_d.right = sid_q;
        s_d.start = LW'(32'(s_q.start) + 32'(req_q));
        s_d.size = SW'(32'(s_q.size) - 32'(req_q));
        s_d.has_left = 1'b1;
        s_d.left = nid_q;
        if (s_q.has_left) begin
          rmw_id_d = s_q.left;
          rmw_kind_d = K_RIGHT;
          rmw_has_d = 1'b1;
          rmw_val_d = nid_q;
          rmw_ret_d = S_A_SP2;
          st_d = S_RMW_RD;
        end else begin
          st_d = S_A_SP2;
        end
      end
      S_A_SP2: begin
        pu_ret_d = S_A_SP3;
        st_d = S_PU0;
      end
      S_A_SP3: begin
        node_we = 1'b1;
        node_waddr = nid_q;
        node_wdata = n_q;
        aux_we = 1'b1;
        aux_waddr = AW'(n_q.start);
        aux_wdata = nid_q;
        res_st_d = ST_OK;
        res_loc_d = 12'(n_q.start);
        st_d = S_DONE;
      end
      S_F_MAP: begin
        sid_d = aux_rdata;
        node_raddr = aux_rdata;
        st_d = S_F_SRD;
      end
      S_F_SRD: begin
        s_d = node_rdata;
        // a table entry counts only while its node is live and still starts here
        if (!((32'(sid_q) < 32'(fresh_q)) && node_rdata.used &&
              (32'(node_rdata.start) == 32'(loc_q)))) begin
          res_st_d = ST_BAD_LOC;
          res_loc_d = '0;
          st_d = S_DONE;
        end else if (node_rdata.has_left) begin
          pid_d = node_rdata.left;
          node_raddr = node_rdata.left;
          st_d = S_F_LRD;
        end else begin
          st_d = S_F_R0;
        end
      end
      S_F_LRD: begin
        p_d = node_rdata;
        if (node_rdata.used) begin
          st_d = S_F_R0;
        end else begin
          rm_d = node_rdata;
          rm_ret_d = S_F_L2;
          st_d = S_RM0;
        end
      end
      S_F_L2: begin
        s_d.start = p_q.start;
        s_d.size = SW'(32'(s_q.size) + 32'(p_q.size));
        s_d.has_left = p_q.has_left;
        s_d.left = p_q.left;
        if (p_q.has_left) begin
          rmw_id_d = p_q.left;
          rmw_kind_d = K_RIGHT;
          rmw_has_d = 1'b1;
          rmw_val_d = sid_q;
          rmw_ret_d = S_F_L3;
          st_d = S_RMW_RD;
        end else begin
          st_d = S_F_L3;
        end
      end
      S_F_L3, S_F_R3: begin
        // release the merged id onto the recycle stack linked through cnext
        w = p_q;
        w.has_cnext = top_v_q;
        w.cnext = top_q;
        node_we = 1'b1;
        node_waddr = pid_q;
        node_wdata = w;
        top_d = pid_q;
        top_v_d = 1'b1;
        st_d = (st_q == S_F_L3) ? S_F_R0 : S_F_PU;
      end
      S_F_R0: begin
        if (s_q.has_right) begin
          pid_d = s_q.right;
          node_raddr = s_q.right;
          st_d = S_F_RRD;
        end else begin
          st_d = S_F_PU;
        end
      end
      S_F_RRD: begin
        p_d = node_rdata;
        if (node_rdata.used) begin
          st_d = S_F_PU;
        end else begin
          rm_d = node_rdata;
          rm_ret_d = S_F_R2;
          st_d = S_RM0;
        end
      end
      S_F_R2: begin
        s_d.size = SW'(32'(s_q.size) + 32'(p_q.size));
        s_d.has_right = p_q.has_right;
        s_d.right = p_q.right;
        if (p_q.has_right) begin
          rmw_id_d = p_q.right;
          rmw_kind_d = K_LEFT;
          rmw_has_d = 1'b1;
          rmw_val_d = sid_q;
          rmw_ret_d = S_F_R3;
          st_d = S_RMW_RD;
        end else begin
          st_d = S_F_R3;
        end
      end
      S_F_PU: begin
        s_d.used = 1'b0;
        pu_ret_d = S_F_DONE;
        st_d = S_PU0;
      end
      S_F_DONE: begin
        res_st_d = ST_OK;
        res_loc_d = '0;
        st_d = S_DONE;
      end
      S_RM0: begin
        c = cls_of(rm_q.size);
        if (rm_q.has_cprev) begin
          rmw_id_d = rm_q.cprev;
          rmw_kind_d = K_NEXT;
          rmw_has_d = rm_q.has_cnext;
          rmw_val_d = rm_q.cnext;
          rmw_ret_d = S_RM1;
          st_d = S_RMW_RD;
        end else begin
          aux_we = 1'b1;
          aux_waddr = AW'(DISK_CHUNKS + 32'(c));
          aux_wdata = rm_q.cnext;
          occ_cmd.wr = 1'b1;
          occ_cmd.val = rm_q.has_cnext;
          occ_widx = c;
          st_d = S_RM1;
        end
      end
      S_RM1: begin
        if (rm_q.has_cnext) begin
          rmw_id_d = rm_q.cnext;
          rmw_kind_d = K_PREV;
          rmw_has_d = rm_q.has_cprev;
          rmw_val_d = rm_q.cprev;
          rmw_ret_d = rm_ret_q;
          st_d = S_RMW_RD;
        end else begin
          st_d = rm_ret_q;
        end
      end
      S_PU0: begin
        c = cls_of(s_q.size);
        occ_qidx = c;
        if (occ_qbit) begin
          aux_raddr = AW'(DISK_CHUNKS + 32'(c));
          st_d = S_PU1;
        end else begin
          w = s_q;
          w.has_cprev = 1'b0;
          w.has_cnext = 1'b0;
          node_we = 1'b1;
          node_waddr = sid_q;
          node_wdata = w;
          aux_we = 1'b1;
          aux_waddr = AW'(DISK_CHUNKS + 32'(c));
          aux_wdata = sid_q;
          occ_cmd.wr = 1'b1;
          occ_cmd.val = 1'b1;
          occ_widx = c;
          st_d = pu_ret_q;
        end
      end
      S_PU1: begin
        c = cls_of(s_q.size);
        w = s_q;
        w.has_cprev = 1'b0;
        w.has_cnext = 1'b1;
        w.cnext = aux_rdata;
        node_we = 1'b1;
        node_waddr = sid_q;
        node_wdata = w;
        aux_we = 1'b1;
        aux_waddr = AW'(DISK_CHUNKS + 32'(c));
        aux_wdata = sid_q;
        occ_cmd.wr = 1'b1;
        occ_cmd.val = 1'b1;
        occ_widx = c;
        rmw_id_d = aux_rdata;
        rmw_kind_d = K_PREV;
        rmw_has_d = 1'b1;
        rmw_val_d = sid_q;
        rmw_ret_d = pu_ret_q;
        st_d = S_RMW_RD;
      end
      S_RMW_RD: begin
        node_raddr = rmw_id_q;
        st_d = S_RMW_WR;
      end
      S_RMW_WR: begin
        w = node_rdata;
        case (rmw_kind_q)
          K_NEXT: begin
            w.has_cnext = rmw_has_q;
            w.cnext = rmw_val_q;
          end
          K_PREV: begin
            w.has_cprev = rmw_has_q;
            w.cprev = rmw_val_q;
          end
          K_RIGHT: w.right = rmw_val_q;
          default: w.left = rmw_val_q;
        endcase
        node_we = 1'b1;
        node_waddr = rmw_id_q;
        node_wdata = w;
        st_d = rmw_ret_q;
      end
      default: st_d = S_IDLE;
    endcase

    if (cfg_valid_i) begin
      disk_d = SW'(cfg_sat);
      rb_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
      rm_ret_q <= S_IDLE;
      pu_ret_q <= S_IDLE;
      rmw_ret_q <= S_IDLE;
      disk_q <= SW'(DISK_CHUNKS);
      rb_pend_q <= 1'b1;
      clr_q <= '0;
      fresh_q <= FW'(1);
      top_q <= '0;
      top_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rm_ret_q <= rm_ret_d;
      pu_ret_q <= pu_ret_d;
      rmw_ret_q <= rmw_ret_d;
      disk_q <= disk_d;
      rb_pend_q <= rb_pend_d;
      clr_q <= clr_d;
      fresh_q <= fresh_d;
      top_q <= top_d;
      top_v_q <= top_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    res_st_q <= res_st_d;
    res_loc_q <= res_loc_d;
    req_q <= req_d;
    loc_q <= loc_d;
    sid_q <= sid_d;
    pid_q <= pid_d;
    nid_q <= nid_d;
    s_q <= s_d;
    p_q <= p_d;
    n_q <= n_d;
    rm_q <= rm_d;
    rmw_id_q <= rmw_id_d;
    rmw_val_q <= rmw_val_d;
    rmw_kind_q <= rmw_kind_d;
    rmw_has_q <= rmw_has_d;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import sfca_pkg::*;

  localparam int NODES     = 4096;
  localparam int CHUNKS    = 4096;
  localparam int MAX_REQ   = 320;
  localparam int CLASSES   = 322;
  localparam int WD_LIMIT  = 20000;
  localparam int SETTLE    = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;

  segregated_fit_chunk_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // allocator mirror: node table, size-class lists, start-chunk lookup
  logic [12:0] seg_start [NODES];
  logic [12:0] seg_size  [NODES];
  bit          seg_used  [NODES];
  bit          nb_has_l  [NODES];
  bit          nb_has_r  [NODES];
  logic [11:0] nb_l      [NODES];
  logic [11:0] nb_r      [NODES];
  bit          cl_has_p  [NODES];
  bit          cl_has_n  [NODES];
  logic [11:0] cl_p      [NODES];
  logic [11:0] cl_n      [NODES];
  bit          head_ok   [CLASSES];
  logic [11:0] head_id   [CLASSES];
  bit          loc_ok    [CHUNKS];
  logic [11:0] loc_id    [CHUNKS];
  logic [11:0] spare_ids [$];
  int          next_fresh;
  logic [12:0] disk_chunks;

  logic [11:0] live_starts [$];
  out_t        pending_replies [$];

  int send_idle_pct, recv_idle_pct;
  int errors, items_sent, replies_seen, n_ok, n_bad_size, n_no_space, n_bad_loc;
  int quiet_cycles;

  function automatic int class_of(logic [12:0] sz);
    return (sz >= CLASSES - 1) ? CLASSES - 1 : int'(sz);
  endfunction

  function automatic void list_push(logic [11:0] id);
    int c;
    c = class_of(seg_size[id]);
    cl_has_p[id] = 1'b0;
    cl_has_n[id] = head_ok[c];
    cl_n[id] = head_id[c];
    if (head_ok[c]) begin
      cl_has_p[head_id[c]] = 1'b1;
      cl_p[head_id[c]] = id;
    end
    head_ok[c] = 1'b1;
    head_id[c] = id;
  endfunction

  function automatic void list_unlink(logic [11:0] id);
    int c;
    c = class_of(seg_size[id]);
    if (cl_has_p[id]) begin
      cl_has_n[cl_p[id]] = cl_has_n[id];
      cl_n[cl_p[id]] = cl_n[id];
    end else begin
      head_ok[c] = cl_has_n[id];
      head_id[c] = cl_n[id];
    end
    if (cl_has_n[id]) begin
      cl_has_p[cl_n[id]] = cl_has_p[id];
      cl_p[cl_n[id]] = cl_p[id];
    end
  endfunction

  function automatic void rebuild_disk(logic [12:0] chunks);
    disk_chunks = (chunks > CHUNKS) ? 13'(CHUNKS) : chunks;
    for (int i = 0; i < NODES; i++) begin
      seg_start[i] = '0; seg_size[i] = '0; seg_used[i] = 1'b0;
      nb_has_l[i] = 1'b0; nb_has_r[i] = 1'b0; nb_l[i] = '0; nb_r[i] = '0;
      cl_has_p[i] = 1'b0; cl_has_n[i] = 1'b0; cl_p[i] = '0; cl_n[i] = '0;
      loc_ok[i] = 1'b0; loc_id[i] = '0;
    end
    for (int c = 0; c < CLASSES; c++) begin
      head_ok[c] = 1'b0;
      head_id[c] = '0;
    end
    spare_ids.delete();
    live_starts.delete();
    next_fresh = 1;
    seg_size[0] = disk_chunks;
    if (disk_chunks > 0) list_push(12'd0);
  endfunction

  function automatic out_t grant_chunks(logic [8:0] req);
    out_t r;
    logic [11:0] h, n;
    bit found;
    r = '{status: ST_OK, granted_location: '0};
    found = 1'b0;
    h = '0;
    if (req == 0 || req > MAX_REQ) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    for (int c = class_of(13'(req)); c < CLASSES; c++) begin
      if (head_ok[c] && seg_size[head_id[c]] >= req) begin
        h = head_id[c];
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    if (seg_size[h] == req) begin
      list_unlink(h);
      seg_used[h] = 1'b1;
    end else begin
      if (spare_ids.size() > 0) n = spare_ids.pop_back();
      else if (next_fresh < NODES) n = 12'(next_fresh++);
      else begin
        r.status = ST_NO_SPACE;
        return r;
      end
      list_unlink(h);
      seg_start[n] = seg_start[h];
      seg_size[n] = 13'(req);
      seg_used[n] = 1'b1;
      nb_has_l[n] = nb_has_l[h];
      nb_l[n] = nb_l[h];
      nb_has_r[n] = 1'b1;
      nb_r[n] = h;
      if (nb_has_l[h]) nb_r[nb_l[h]] = n;
      seg_start[h] = seg_start[h] + req;
      seg_size[h] = seg_size[h] - req;
      nb_has_l[h] = 1'b1;
      nb_l[h] = n;
      list_push(h);
      h = n;
    end
    r.granted_location = seg_start[h][11:0];
    loc_ok[seg_start[h][11:0]] = 1'b1;
    loc_id[seg_start[h][11:0]] = h;
    live_starts.push_back(seg_start[h][11:0]);
    return r;
  endfunction

  function automatic out_t release_chunks(logic [11:0] loc);
    out_t r;
    logic [11:0] id, p;
    r = '{status: ST_OK, granted_location: '0};
    if (!loc_ok[loc]) begin
      r.status = ST_BAD_LOC;
      return r;
    end
    id = loc_id[loc];
    loc_ok[loc] = 1'b0;
    foreach (live_starts[i]) begin
      if (live_starts[i] == loc) begin
        live_starts.delete(i);
        break;
      end
    end
    if (nb_has_l[id] && !seg_used[nb_l[id]]) begin
      p = nb_l[id];
      list_unlink(p);
      seg_start[id] = seg_start[p];
      seg_size[id] = seg_size[id] + seg_size[p];
      nb_has_l[id] = nb_has_l[p];
      nb_l[id] = nb_l[p];
      if (nb_has_l[id]) nb_r[nb_l[id]] = id;
      spare_ids.push_back(p);
    end
    if (nb_has_r[id] && !seg_used[nb_r[id]]) begin
      p = nb_r[id];
      list_unlink(p);
      seg_size[id] = seg_size[id] + seg_size[p];
      nb_has_r[id] = nb_has_r[p];
      nb_r[id] = nb_r[p];
      if (nb_has_r[id]) nb_l[nb_r[id]] = id;
      spare_ids.push_back(p);
    end
    seg_used[id] = 1'b0;
    list_push(id);
    return r;
  endfunction

  // drive one beat; valid stays high across back-to-back beats
  task automatic send_item(logic op, logic [8:0] req, logic [11:0] loc);
    out_t exp_r;
    in_valid_i <= 1'b1;
    in_data_i <= '{opcode: op, request_size: req, free_location: loc};
    exp_r = (op == OP_ALLOC) ? grant_chunks(req) : release_chunks(loc);
    pending_replies.push_back(exp_r);
    items_sent++;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_disk(logic [12:0] chunks);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= chunks;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rebuild_disk(chunks);
  endtask

  task automatic alloc_req(logic [8:0] req);
    send_item(OP_ALLOC, req, 12'($urandom));
  endtask

  task automatic free_at(logic [11:0] loc);
    send_item(OP_FREE, 9'($urandom), loc);
  endtask

  task automatic test_size_limits();
    alloc_req(9'd0);
    alloc_req(9'd321);
    alloc_req(9'd511);
    alloc_req(9'd320);
    alloc_req(9'd1);
    alloc_req(9'd1);
    alloc_req(9'd300);
    free_at(12'd4095);
    free_at(12'd321);
    free_at(12'd321);
    free_at(12'd320);
    alloc_req(9'd1);
    free_at(12'd0);
    free_at(12'd322);
  endtask

  task automatic test_tiny_disks();
    set_disk(13'd0);
    alloc_req(9'd1);
    free_at(12'd0);
    set_disk(13'd1);
    alloc_req(9'd2);
    alloc_req(9'd1);
    alloc_req(9'd1);
    free_at(12'd0);
    alloc_req(9'd1);
    set_disk(13'h1FFF);
    alloc_req(9'd320);
    alloc_req(9'd200);
  endtask

  task automatic test_random_traffic(int n_items, logic [12:0] chunks);
    int pick;
    set_disk(chunks);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 52) begin
        if ($urandom_range(9) == 0) alloc_req(9'($urandom_range(1, MAX_REQ)));
        else alloc_req(9'($urandom_range(1, 24)));
      end else if (pick < 88 && live_starts.size() > 0) begin
        free_at(live_starts[$urandom_range(live_starts.size() - 1)]);
      end else if (pick < 94) begin
        alloc_req($urandom_range(1) ? 9'd0 : 9'($urandom_range(MAX_REQ + 1, 511)));
      end else begin
        free_at(12'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat status=%0d loc=%0d", $time,
                 out_data_o.status, out_data_o.granted_location);
      end else begin
        exp_r = pending_replies.pop_front();
        case (exp_r.status)
          ST_OK:       n_ok++;
          ST_BAD_SIZE: n_bad_size++;
          ST_NO_SPACE: n_no_space++;
          default:     n_bad_loc++;
        endcase
        if (out_data_o.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, out_data_o.status);
        end
        if (out_data_o.granted_location !== exp_r.granted_location) begin
          errors++;
          $display("%0t: granted_location expected %0d actual %0d", $time,
                   exp_r.granted_location, out_data_o.granted_location);
        end
      end
    end
  end

  // count cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog expired, %0d replies outstanding", $time,
               pending_replies.size());
      $display("** segregated_fit_chunk_allocator_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0; items_sent = 0; replies_seen = 0; quiet_cycles = 0;
    n_ok = 0; n_bad_size = 0; n_no_space = 0; n_bad_loc = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rebuild_disk(13'(CHUNKS));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_size_limits();
    test_tiny_disks();
    send_idle_pct = 6;
    recv_idle_pct = 82;
    test_random_traffic(210, 13'd4096);
    send_idle_pct = 82;
    recv_idle_pct = 6;
    test_random_traffic(210, 13'd300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(210, 13'd1000);
    wait_drained();
    $display("Sent %0d requests over disk sizes 0 to 4096 with three stall mixes;", items_sent);
    $display("replies: %0d ok, %0d bad size, %0d no space, %0d bad location, %0d errors",
             n_ok, n_bad_size, n_no_space, n_bad_loc, errors);
    if (errors == 0) begin
      $display("** segregated_fit_chunk_allocator_unit: PASSED **");
    end else begin
      $display("** segregated_fit_chunk_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
